[hw/rtl/smcu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcu_pkg
// Shared types, command codes and timing constants for the 8080 stack, I/O
// and machine-control execute unit.
// ----------------------------------------------------------------------------
package smcu_pkg;

  // command codes
  typedef enum logic [3:0] {
    CMD_PUSH      = 4'd0,
    CMD_POP       = 4'd1,
    CMD_XTHL      = 4'd2,
    CMD_SPHL      = 4'd3,
    CMD_IN        = 4'd4,
    CMD_OUT       = 4'd5,
    CMD_EI        = 4'd6,
    CMD_DI        = 4'd7,
    CMD_HLT       = 4'd8,
    CMD_LOAD_PAIR = 4'd9,
    CMD_LOAD_SP   = 4'd10
  } cmd_e;

  // register pair select codes
  typedef enum logic [1:0] {
    SEL_BC  = 2'd0,
    SEL_DE  = 2'd1,
    SEL_HL  = 2'd2,
    SEL_PSW = 2'd3
  } sel_e;

  // clock states per instruction (published 8080 timing)
  localparam logic [4:0] CYC_PUSH = 5'd11;
  localparam logic [4:0] CYC_POP  = 5'd10;
  localparam logic [4:0] CYC_XTHL = 5'd18;
  localparam logic [4:0] CYC_SPHL = 5'd5;
  localparam logic [4:0] CYC_IO   = 5'd10;
  localparam logic [4:0] CYC_INTE = 5'd4;
  localparam logic [4:0] CYC_HLT  = 5'd7;
  localparam logic [4:0] CYC_NONE = 5'd0;

  localparam logic [7:0]  NO_DEVICE_BYTE = 8'hFF;
  localparam logic [15:0] SP_STEP        = 16'd2;

  // stream widths
  localparam int unsigned IN_BITS  = 55;
  localparam int unsigned IN_BYTES = (IN_BITS + 7) / 8;
  localparam int unsigned OUT_BITS  = 89;
  localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

  // architectural register file
  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  flags;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    logic        ie;
    logic        halt;
  } arch_state_t;

  // one instruction, field order matches the stream packing
  typedef struct packed {
    logic [15:0] load_value;
    logic [7:0]  stack_high_byte;
    logic [7:0]  stack_low_byte;
    logic        port_in_present;
    logic [7:0]  port_in_data;
    logic [7:0]  port_address;
    logic [1:0]  pair_select;
    logic [3:0]  command;
  } in_item_t;

  // one result, field order matches the stream packing
  typedef struct packed {
    logic        halted;
    logic        interrupts_enabled;
    logic [15:0] stack_pointer;
    logic [15:0] pair_value;
    logic [7:0]  port_out_data;
    logic [7:0]  port_out_address;
    logic        port_write;
    logic [7:0]  mem_high_byte;
    logic [7:0]  mem_low_byte;
    logic [15:0] mem_address;
    logic        mem_write;
    logic [4:0]  cycle_count;
  } out_item_t;

  // read a register pair, psw is accumulator over flags
  function automatic logic [15:0] read_pair(arch_state_t st, logic [1:0] sel);
    logic [15:0] v;
    case (sel)
      SEL_BC:  v = st.bc;
      SEL_DE:  v = st.de;
      SEL_HL:  v = st.hl;
      SEL_PSW: v = {st.acc, st.flags};
      default: v = st.bc;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/smcu_exec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcu_exec
// Single-pass execute logic: takes one instruction and the current register
// file, produces the next register file and the result item.
// ----------------------------------------------------------------------------
module smcu_exec
  import smcu_pkg::*;
(
  input  in_item_t    item_i,
  input  arch_state_t state_i,
  output arch_state_t state_o,
  output out_item_t   result_o
);

  arch_state_t nxt;
  out_item_t   res;
  logic [15:0] pair_cur;
  logic [15:0] stack_word;

  assign pair_cur   = read_pair(state_i, item_i.pair_select);
  assign stack_word = {item_i.stack_high_byte, item_i.stack_low_byte};

  // next state and side-effect fields
  always_comb begin
    nxt = state_i;
    res = '0;
    case (item_i.command)
      CMD_PUSH: begin
        nxt.sp            = state_i.sp - SP_STEP;
        res.mem_write     = 1'b1;
        res.mem_address   = state_i.sp - SP_STEP;
        res.mem_low_byte  = pair_cur[7:0];
        res.mem_high_byte = pair_cur[15:8];
        res.cycle_count   = CYC_PUSH;
      end
      CMD_POP: begin
        case (item_i.pair_select)
          SEL_BC:  nxt.bc = stack_word;
          SEL_DE:  nxt.de = stack_word;
          SEL_HL:  nxt.hl = stack_word;
          default: begin
            nxt.acc   = stack_word[15:8];
            nxt.flags = stack_word[7:0];
          end
        endcase
        nxt.sp          = state_i.sp + SP_STEP;
        res.cycle_count = CYC_POP;
      end
      CMD_XTHL: begin
        res.mem_write     = 1'b1;
        res.mem_address   = state_i.sp;
        res.mem_low_byte  = state_i.hl[7:0];
        res.mem_high_byte = state_i.hl[15:8];
        nxt.hl            = stack_word;
        res.cycle_count   = CYC_XTHL;
      end
      CMD_SPHL: begin
        nxt.sp          = state_i.hl;
        res.cycle_count = CYC_SPHL;
      end
      CMD_IN: begin
        // absent device reads as all ones
        nxt.acc         = item_i.port_in_present ? item_i.port_in_data : NO_DEVICE_BYTE;
        res.cycle_count = CYC_IO;
      end
      CMD_OUT: begin
        res.port_write       = 1'b1;
        res.port_out_address = item_i.port_address;
        res.port_out_data    = state_i.acc;
        res.cycle_count      = CYC_IO;
      end
      CMD_EI: begin
        nxt.ie          = 1'b1;
        res.cycle_count = CYC_INTE;
      end
      CMD_DI: begin
        nxt.ie          = 1'b0;
        res.cycle_count = CYC_INTE;
      end
      CMD_HLT: begin
        nxt.halt        = 1'b1;
        res.cycle_count = CYC_HLT;
      end
      CMD_LOAD_PAIR: begin
        case (item_i.pair_select)
          SEL_BC:  nxt.bc = item_i.load_value;
          SEL_DE:  nxt.de = item_i.load_value;
          SEL_HL:  nxt.hl = item_i.load_value;
          default: begin
            nxt.acc   = item_i.load_value[15:8];
            nxt.flags = item_i.load_value[7:0];
          end
        endcase
        res.cycle_count = CYC_NONE;
      end
      CMD_LOAD_SP: begin
        nxt.sp          = item_i.load_value;
        res.cycle_count = CYC_NONE;
      end
      default: begin
        // unknown codes leave the state alone
        res.cycle_count = CYC_NONE;
      end
    endcase
  end

  // status fields report the state after the step
  always_comb begin
    result_o                    = res;
    result_o.pair_value         = read_pair(nxt, item_i.pair_select);
    result_o.stack_pointer      = nxt.sp;
    result_o.interrupts_enabled = nxt.ie;
    result_o.halted             = nxt.halt;
  end

  assign state_o = nxt;

endmodule

[hw/rtl/smcu_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcu_state
// Architectural register file: A, flags, BC, DE, HL, SP, interrupt enable
// and halt, all cleared by reset and loaded once per executed instruction.
// ----------------------------------------------------------------------------
module smcu_state
  import smcu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  arch_state_t state_i,
  output arch_state_t state_o
);

  arch_state_t state_q;
  arch_state_t state_d;

  // hold unless an instruction retires
  always_comb begin
    state_d = load_i ? state_i : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

[hw/rtl/stack_and_machine_control_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_and_machine_control_unit_core
// Execute unit for the 8080 stack, I/O and machine-control instructions.
// ----------------------------------------------------------------------------
// Each transfer on the slave stream is one instruction; it is captured in an
// input register, executed in a single pass against the register file and
// its result lands in an output register when the instruction executes,
// which waits while the output register is held by the master side.
// One instruction per cycle is sustained unless the master side stalls: the
// input register refills in the same cycle the previous instruction moves to
// the output register, freed by the master-side transfer in that same cycle.
// Stack memory is external: bytes to pop arrive with the instruction and
// bytes to push leave in the result. The program counter is not kept.
module stack_and_machine_control_unit_core
  import smcu_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command, pair_select, port_address, port_in_data, port_in_present,
  // stack_low_byte, stack_high_byte, load_value
  input  logic [IN_BYTES*8-1:0]    s_axis_tdata_i,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // cycle_count, mem_write, mem_address, mem_low_byte, mem_high_byte,
  // port_write, port_out_address, port_out_data, pair_value,
  // stack_pointer, interrupts_enabled, halted
  output logic [OUT_BYTES*8-1:0]   m_axis_tdata_o,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i
);

  in_item_t    in_q;
  logic        in_valid_q;
  out_item_t   out_q;
  logic        out_valid_q;
  logic        out_free;
  logic        exec_fire;
  logic        in_fire;
  arch_state_t state_cur;
  arch_state_t state_nxt;
  out_item_t   result;

  // handshake control
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign exec_fire       = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || exec_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_item_t'(s_axis_tdata_i[IN_BITS-1:0]);
    end
  end

  // register file
  smcu_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (exec_fire),
    .state_i (state_nxt),
    .state_o (state_cur)
  );

  // execute
  smcu_exec u_exec (
    .item_i   (in_q),
    .state_i  (state_cur),
    .state_o  (state_nxt),
    .result_o (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= exec_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, out_q};

`ifndef SYNTH
  // an executed instruction always shows up at the output
  a_exec_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> out_valid_q)
    else $error("executed instruction did not reach output register");

  // only reset clears the halt flag
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_cur.halt |=> state_cur.halt)
    else $error("halt flag cleared without reset");

  // a waiting instruction is not dropped
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !exec_fire) |=> in_valid_q)
    else $error("pending instruction lost");

  // stack write and port write never come from the same instruction
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.mem_write && out_q.port_write))
    else $error("memory and port write in one result");
`endif

endmodule

[tb/stack_and_machine_control_unit_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_and_machine_control_unit_core_tb
// Self-checking bench for the 8080 stack, I/O and machine-control execute
// unit. A short scripted sequence covers reset state, SP wrap, absent input
// devices, unknown commands and halt. Random instructions follow. Every
// result transfer is compared field by field against a scripted golden
// result or the in-bench instruction executor, with random gaps on both
// streams and one long output stall.
// ----------------------------------------------------------------------------
module stack_and_machine_control_unit_core_tb;
  import smcu_pkg::*;

  localparam int unsigned IN_PAD        = IN_BYTES * 8 - IN_BITS;
  localparam int unsigned RANDOM_INSTRS = 1875;
  localparam int unsigned STALL_AFTER   = 400;
  localparam int unsigned STALL_CYCLES  = 120;

  // command codes the unit does not implement
  localparam logic [3:0] CMD_UNUSED_LO = 4'd11;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  // register file as the bench tracks it
  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  flags;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
    logic        ie;
    logic        halt;
  } cpu_regs_t;

  // one scripted instruction, golden result only where it is obvious
  typedef struct {
    in_item_t  instr;
    bit        has_golden;
    out_item_t golden;
  } script_step_t;

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic [IN_BYTES*8-1:0]  src_data    = '0;
  logic                   src_valid   = 1'b0;
  logic                   s_axis_tready_o;
  logic [OUT_BYTES*8-1:0] m_axis_tdata_o;
  logic                   m_axis_tvalid_o;
  logic                   sink_ready  = 1'b0;
  logic                   hold_off    = 1'b0;

  cpu_regs_t    cpu_model;
  out_item_t    expected_results[$];
  script_step_t script[$];
  int unsigned  accepted_count = 0;
  int unsigned  result_index   = 0;
  int unsigned  mismatch_count = 0;

  stack_and_machine_control_unit_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (src_data),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (sink_ready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #8_000_000;
    $display("stack_and_machine_control_unit_core_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // instruction executor
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] pair_of(input cpu_regs_t r, input logic [1:0] sel);
    logic [15:0] word;
    case (sel)
      SEL_BC:  word = r.bc;
      SEL_DE:  word = r.de;
      SEL_HL:  word = r.hl;
      default: word = {r.acc, r.flags};
    endcase
    return word;
  endfunction

  function automatic cpu_regs_t with_pair(input cpu_regs_t r, input logic [1:0] sel,
                                          input logic [15:0] word);
    cpu_regs_t n;
    n = r;
    case (sel)
      SEL_BC:  n.bc = word;
      SEL_DE:  n.de = word;
      SEL_HL:  n.hl = word;
      default: begin
        n.acc   = word[15:8];
        n.flags = word[7:0];
      end
    endcase
    return n;
  endfunction

  function automatic out_item_t execute_instr(inout cpu_regs_t r, input in_item_t it);
    out_item_t   res;
    logic [15:0] word;
    res = '0;
    case (it.command)
      CMD_PUSH: begin
        word              = pair_of(r, it.pair_select);
        r.sp              = r.sp - SP_STEP;
        res.mem_write     = 1'b1;
        res.mem_address   = r.sp;
        res.mem_low_byte  = word[7:0];
        res.mem_high_byte = word[15:8];
        res.cycle_count   = CYC_PUSH;
      end
      CMD_POP: begin
        r = with_pair(r, it.pair_select, {it.stack_high_byte, it.stack_low_byte});
        r.sp            = r.sp + SP_STEP;
        res.cycle_count = CYC_POP;
      end
      CMD_XTHL: begin
        res.mem_write     = 1'b1;
        res.mem_address   = r.sp;
        res.mem_low_byte  = r.hl[7:0];
        res.mem_high_byte = r.hl[15:8];
        r.hl              = {it.stack_high_byte, it.stack_low_byte};
        res.cycle_count   = CYC_XTHL;
      end
      CMD_SPHL: begin
        r.sp            = r.hl;
        res.cycle_count = CYC_SPHL;
      end
      CMD_IN: begin
        r.acc           = it.port_in_present ? it.port_in_data : NO_DEVICE_BYTE;
        res.cycle_count = CYC_IO;
      end
      CMD_OUT: begin
        res.port_write       = 1'b1;
        res.port_out_address = it.port_address;
        res.port_out_data    = r.acc;
        res.cycle_count      = CYC_IO;
      end
      CMD_EI: begin
        r.ie            = 1'b1;
        res.cycle_count = CYC_INTE;
      end
      CMD_DI: begin
        r.ie            = 1'b0;
        res.cycle_count = CYC_INTE;
      end
      CMD_HLT: begin
        r.halt          = 1'b1;
        res.cycle_count = CYC_HLT;
      end
      CMD_LOAD_PAIR: r = with_pair(r, it.pair_select, it.load_value);
      CMD_LOAD_SP:   r.sp = it.load_value;
      default: ;
    endcase
    // status always reflects the register file after the instruction
    res.pair_value         = pair_of(r, it.pair_select);
    res.stack_pointer      = r.sp;
    res.interrupts_enabled = r.ie;
    res.halted             = r.halt;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t mk_instr(input logic [3:0] cmd, input logic [1:0] sel,
                                        input logic [7:0] port, input logic [7:0] pdata,
                                        input logic present, input logic [7:0] slo,
                                        input logic [7:0] shi, input logic [15:0] lval);
    in_item_t it;
    it.command         = cmd;
    it.pair_select     = sel;
    it.port_address    = port;
    it.port_in_data    = pdata;
    it.port_in_present = present;
    it.stack_low_byte  = slo;
    it.stack_high_byte = shi;
    it.load_value      = lval;
    return it;
  endfunction

  function automatic out_item_t mk_golden(input logic [4:0] cyc, input logic mw,
                                          input logic [15:0] maddr, input logic [7:0] mlo,
                                          input logic [7:0] mhi, input logic [15:0] pair,
                                          input logic [15:0] sp);
    out_item_t res;
    res                    = '0;
    res.cycle_count        = cyc;
    res.mem_write          = mw;
    res.mem_address        = maddr;
    res.mem_low_byte       = mlo;
    res.mem_high_byte      = mhi;
    res.pair_value         = pair;
    res.stack_pointer      = sp;
    return res;
  endfunction

  task automatic add_step(input in_item_t it, input bit has_golden, input out_item_t golden);
    script_step_t st;
    st.instr      = it;
    st.has_golden = has_golden;
    st.golden     = golden;
    script.push_back(st);
  endtask

  function automatic in_item_t random_instr();
    in_item_t it;
    if ($urandom_range(0, 99) < 5)
      it.command = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    else
      it.command = 4'($urandom_range(CMD_PUSH, CMD_LOAD_SP));
    it.pair_select     = 2'($urandom);
    it.port_address    = 8'($urandom);
    it.port_in_data    = 8'($urandom);
    it.port_in_present = 1'($urandom);
    it.stack_low_byte  = 8'($urandom);
    it.stack_high_byte = 8'($urandom);
    it.load_value      = 16'($urandom);
    return it;
  endfunction

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one instruction and record what it should produce
  task automatic drive_instr(input in_item_t it, input bit has_golden,
                             input out_item_t golden, input int idx);
    int        gap;
    out_item_t predicted;
    gap = (hold_off || ((idx / 160) % 5 == 3)) ? 0 : pick_gap();
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_data  <= {{IN_PAD{1'b0}}, it};
    src_valid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = execute_instr(cpu_model, it);
    expected_results.push_back(has_golden ? golden : predicted);
    accepted_count++;
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int idx,
                                 input logic [15:0] got, input logic [15:0] want);
    mismatch_count++;
    $display("result %0d: %s got 0x%0h want 0x%0h", idx, what, got, want);
  endtask

  task automatic check_field(input string what, input int idx,
                             input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch(what, idx, got, want);
  endtask

  // compare every result transfer with the oldest pending expectation
  always @(posedge clk_i) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_ni && m_axis_tvalid_o && sink_ready) begin
      got = out_item_t'(m_axis_tdata_o[OUT_BITS-1:0]);
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", result_index, 16'h0, 16'h0);
      end else begin
        want = expected_results.pop_front();
        check_field("cycle_count", result_index, 16'(got.cycle_count),
                    16'(want.cycle_count));
        check_field("mem_write", result_index, 16'(got.mem_write), 16'(want.mem_write));
        check_field("mem_address", result_index, got.mem_address, want.mem_address);
        check_field("mem_low_byte", result_index, 16'(got.mem_low_byte),
                    16'(want.mem_low_byte));
        check_field("mem_high_byte", result_index, 16'(got.mem_high_byte),
                    16'(want.mem_high_byte));
        check_field("port_write", result_index, 16'(got.port_write), 16'(want.port_write));
        check_field("port_out_address", result_index, 16'(got.port_out_address),
                    16'(want.port_out_address));
        check_field("port_out_data", result_index, 16'(got.port_out_data),
                    16'(want.port_out_data));
        check_field("pair_value", result_index, got.pair_value, want.pair_value);
        check_field("stack_pointer", result_index, got.stack_pointer, want.stack_pointer);
        check_field("interrupts_enabled", result_index, 16'(got.interrupts_enabled),
                    16'(want.interrupts_enabled));
        check_field("halted", result_index, 16'(got.halted), 16'(want.halted));
        check_field("padding", result_index,
                    16'(m_axis_tdata_o[OUT_BYTES*8-1:OUT_BITS]), 16'h0);
      end
      result_index++;
    end
  end

  // ---------------------------------------------------------------------------
  // output side ready: random stalls, quiet stretches, one long hold-off
  // ---------------------------------------------------------------------------

  initial begin : sink_pacing
    int stall_left;
    int cyc;
    stall_left = 0;
    cyc        = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_off) begin
        sink_ready <= 1'b0;
      end else if (stall_left > 0) begin
        sink_ready <= 1'b0;
        stall_left--;
      end else begin
        sink_ready <= 1'b1;
        if ((cyc / 256) % 4 != 2) stall_left = pick_gap();
      end
    end
  end

  // long output stall while the input keeps offering, fills the pipeline
  initial begin : output_hold
    wait (accepted_count >= STALL_AFTER);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // reset, stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int idx;
    cpu_model = '0;

    // reset state, SP wrap in both directions, absent device
    add_step(mk_instr(CMD_UNUSED_HI, SEL_BC, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b1, mk_golden(CYC_NONE, 1'b0, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000));
    add_step(mk_instr(CMD_IN, SEL_PSW, 8'h00, 8'h5A, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b1, mk_golden(CYC_IO, 1'b0, 16'h0000, 8'h00, 8'h00, 16'hFF00, 16'h0000));
    add_step(mk_instr(CMD_PUSH, SEL_PSW, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b1, mk_golden(CYC_PUSH, 1'b1, 16'hFFFE, 8'h00, 8'hFF, 16'hFF00, 16'hFFFE));
    add_step(mk_instr(CMD_POP, SEL_BC, 8'h00, 8'h00, 1'b0, 8'hFF, 8'hFF, 16'h0000),
             1'b1, mk_golden(CYC_POP, 1'b0, 16'h0000, 8'h00, 8'h00, 16'hFFFF, 16'h0000));
    // loads, flag byte kept whole, xthl at the top of memory
    add_step(mk_instr(CMD_LOAD_PAIR, SEL_PSW, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'hA55A),
             1'b0, '0);
    add_step(mk_instr(CMD_PUSH, SEL_PSW, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b0, '0);
    add_step(mk_instr(CMD_LOAD_PAIR, SEL_HL, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'hFFFF),
             1'b0, '0);
    add_step(mk_instr(CMD_LOAD_PAIR, SEL_DE, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'h8001),
             1'b0, '0);
    add_step(mk_instr(CMD_LOAD_SP, SEL_HL, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'hFFFF),
             1'b0, '0);
    add_step(mk_instr(CMD_XTHL, SEL_HL, 8'h00, 8'h00, 1'b0, 8'h00, 8'h80, 16'h0000),
             1'b0, '0);
    add_step(mk_instr(CMD_SPHL, SEL_HL, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b0, '0);
    add_step(mk_instr(CMD_POP, SEL_PSW, 8'h00, 8'h00, 1'b0, 8'hFF, 8'h00, 16'h0000),
             1'b0, '0);
    // port writes and reads at the address extremes
    add_step(mk_instr(CMD_OUT, SEL_PSW, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b0, '0);
    add_step(mk_instr(CMD_IN, SEL_PSW, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 16'h0000),
             1'b0, '0);
    add_step(mk_instr(CMD_OUT, SEL_DE, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b0, '0);
    add_step(mk_instr(CMD_IN, SEL_PSW, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00, 16'h0000),
             1'b0, '0);
    // interrupt enable and halt, execution continues while halted
    add_step(mk_instr(CMD_EI, SEL_BC, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b0, '0);
    add_step(mk_instr(CMD_DI, SEL_BC, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b0, '0);
    add_step(mk_instr(CMD_EI, SEL_HL, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b0, '0);
    add_step(mk_instr(CMD_HLT, SEL_DE, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b0, '0);
    add_step(mk_instr(CMD_PUSH, SEL_BC, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b0, '0);
    // unknown commands leave state alone
    add_step(mk_instr(CMD_UNUSED_LO, SEL_HL, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 16'hFFFF),
             1'b0, '0);
    add_step(mk_instr(4'(CMD_UNUSED_LO + 4'd1), SEL_DE, 8'h00, 8'h00, 1'b0, 8'h00,
                      8'h00, 16'h0000), 1'b0, '0);
    add_step(mk_instr(CMD_LOAD_SP, SEL_BC, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 16'h0000),
             1'b0, '0);
    add_step(mk_instr(CMD_POP, SEL_DE, 8'h00, 8'h00, 1'b0, 8'h01, 8'h02, 16'h0000),
             1'b0, '0);

    // reset held at the start, then released
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idx = 0;
    foreach (script[i]) begin
      drive_instr(script[i].instr, script[i].has_golden, script[i].golden, idx);
      idx++;
    end
    repeat (RANDOM_INSTRS) begin
      drive_instr(random_instr(), 1'b0, '0, idx);
      idx++;
    end
    src_valid <= 1'b0;

    // drain, then watch a little longer for stray results
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("stack_and_machine_control_unit_core_tb: PASS");
    end else begin
      $display("stack_and_machine_control_unit_core_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/smcu_pkg.sv
hw/rtl/smcu_exec.sv
hw/rtl/smcu_state.sv
hw/rtl/stack_and_machine_control_unit_core.sv
tb/stack_and_machine_control_unit_core_tb.sv
